[rtl/b64_pkg.sv]
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, codes and character tables of the base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

	// mode register codes
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// padding and terminator character
	localparam logic [7:0] PAD_CHAR = 8'h3D;
	// highest control or space character
	localparam logic [7:0] CTRL_MAX = 8'h20;

	// results of one request, first byte in bytes[0]
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
	} res_grp_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	// alphabet character to {known, 6-bit value}
	function automatic logic [6:0] dec_sextet(input logic [7:0] c);
		logic [7:0] t;
		logic [6:0] r;
		t = 8'h00;
		r = 7'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
			r = {1'b1, t[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'h61 + 8'd26;
			r = {1'b1, t[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30 + 8'd52;
			r = {1'b1, t[5:0]};
		end else if (c == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

[rtl/b64_in_if.sv]
// ----------------------------------------------------------------------------
// b64_in_if
// Input channel: one byte or character per request, with end-of-message flag.
// ----------------------------------------------------------------------------
interface b64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       last_in;

	modport source(output valid, data_in, last_in, input ready);
	modport sink(input valid, data_in, last_in, output ready);
endinterface

[rtl/b64_out_if.sv]
// ----------------------------------------------------------------------------
// b64_out_if
// Output channel: one character or byte per request, with last-of-run flag.
// ----------------------------------------------------------------------------
interface b64_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source(output valid, out_byte, run_last, input ready);
	modport sink(input valid, out_byte, run_last, output ready);
endinterface

[rtl/b64_step.sv]
// ----------------------------------------------------------------------------
// b64_step
// Combinational group update: folds one element into the open group and
// produces the result group that it completes.
// ----------------------------------------------------------------------------
module b64_step
	import b64_pkg::*;
(
	input  logic        mode,
	input  logic [7:0]  data,
	input  logic        last,
	input  logic [23:0] grp_bits,
	input  logic [1:0]  grp_cnt,
	output logic [23:0] nxt_bits,
	output logic [1:0]  nxt_cnt,
	output res_grp_t    res
);

	logic [1:0]  enc_k;
	logic [23:0] enc_ins;
	logic [1:0]  enc_kn;
	logic [23:0] enc_msk;
	logic        term;
	logic [6:0]  sx;
	logic [23:0] dec_ins;
	logic [2:0]  dec_kn;

	// encode: place byte into the group
	always_comb begin
		enc_k = (grp_cnt == 2'd3) ? 2'd2 : grp_cnt;
		unique case (enc_k)
			2'd0:    enc_ins = {data, grp_bits[15:0]};
			2'd1:    enc_ins = {grp_bits[23:16], data, grp_bits[7:0]};
			default: enc_ins = {grp_bits[23:8], data};
		endcase
		enc_kn = enc_k + 2'd1;
		unique case (enc_kn)
			2'd1:    enc_msk = {enc_ins[23:16], 16'h0000};
			2'd2:    enc_msk = {enc_ins[23:8], 8'h00};
			default: enc_msk = enc_ins;
		endcase
	end

	// decode: classify character and fill its slot
	always_comb begin
		term = (data == PAD_CHAR) || (data <= CTRL_MAX) || data[7];
		sx   = dec_sextet(data);
		dec_ins = grp_bits;
		if (sx[6]) begin
			unique case (grp_cnt)
				2'd0:    dec_ins = {sx[5:0], grp_bits[17:0]};
				2'd1:    dec_ins = {grp_bits[23:18], sx[5:0], grp_bits[11:0]};
				2'd2:    dec_ins = {grp_bits[23:12], sx[5:0], grp_bits[5:0]};
				default: dec_ins = {grp_bits[23:6], sx[5:0]};
			endcase
		end
		dec_kn = {1'b0, grp_cnt} + 3'd1;
	end

	// next state and result group
	always_comb begin
		nxt_bits  = grp_bits;
		nxt_cnt   = grp_cnt;
		res.bytes = '0;
		res.cnt   = 3'd0;
		if (mode == MODE_ENC) begin
			if (enc_kn == 2'd3 || last) begin
				res.bytes[0] = enc_char(enc_msk[23:18]);
				res.bytes[1] = enc_char(enc_msk[17:12]);
				res.bytes[2] = (enc_kn > 2'd1) ? enc_char(enc_msk[11:6]) : PAD_CHAR;
				res.bytes[3] = (enc_kn > 2'd2) ? enc_char(enc_msk[5:0]) : PAD_CHAR;
				res.cnt      = 3'd4;
				nxt_bits     = 24'h000000;
				nxt_cnt      = 2'd0;
			end else begin
				nxt_bits = enc_ins;
				nxt_cnt  = enc_kn;
			end
		end else if (term) begin
			// terminator closes any open group
			res.bytes[0] = grp_bits[23:16];
			res.bytes[1] = grp_bits[15:8];
			res.bytes[2] = grp_bits[7:0];
			nxt_cnt      = 2'd0;
			unique case (grp_cnt)
				2'd0:    res.cnt = 3'd0;
				2'd3:    res.cnt = 3'd2;
				default: res.cnt = 3'd1;
			endcase
		end else begin
			nxt_bits     = dec_ins;
			res.bytes[0] = dec_ins[23:16];
			res.bytes[1] = dec_ins[15:8];
			res.bytes[2] = dec_ins[7:0];
			if (dec_kn == 3'd4 || last) begin
				nxt_cnt = 2'd0;
				unique case (dec_kn)
					3'd4:    res.cnt = 3'd3;
					3'd3:    res.cnt = 3'd2;
					default: res.cnt = 3'd1;
				endcase
			end else begin
				nxt_cnt = dec_kn[1:0];
			end
		end
	end

endmodule

[rtl/b64_ser.sv]
// ----------------------------------------------------------------------------
// b64_ser
// Result buffer: holds one result group and sends it out one byte per request.
// ----------------------------------------------------------------------------
module b64_ser
	import b64_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_grp_t  res,
	output logic      free,
	b64_out_if.source out_ch
);

	logic [3:0][7:0] buf_q;
	logic [2:0]      left_q;
	logic            pop;
	logic            take;

	assign pop  = out_ch.valid && out_ch.ready;
	assign take = load && (res.cnt != 3'd0);
	// empty now, or emptied by this cycle's request
	assign free = (left_q == 3'd0) || (left_q == 3'd1 && out_ch.ready);

	assign out_ch.valid    = (left_q != 3'd0);
	assign out_ch.out_byte = buf_q[0];
	assign out_ch.run_last = (left_q == 3'd1);

	// remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 3'd0;
		end else if (take) begin
			left_q <= res.cnt;
		end else if (pop) begin
			left_q <= left_q - 3'd1;
		end
	end

	// byte shift line
	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= res.bytes;
		end else if (pop) begin
			buf_q <= {8'h00, buf_q[3:1]};
		end
	end

	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> free)
		else $error("result group loaded into a busy buffer");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= 3'd4)
		else $error("result count out of range");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !take) |=> (left_q == $past(left_q) - 3'd1))
		else $error("result count did not drop after a request");

	a_take_count: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (left_q == $past(res.cnt)))
		else $error("result count not loaded");

endmodule

[rtl/base64_codec.sv]
// ----------------------------------------------------------------------------
// base64_codec
// Streaming base64 encoder and decoder selected by a mode register.
// ----------------------------------------------------------------------------
// A request is registered in the input stage, then its result group is loaded
// into the result buffer, which offers the first result. Input requests go one
// per cycle while results drain, but one that yields results waits for a free
// buffer; up to four results leave one per cycle while the receiver is ready.
// Reset clears mode (encode), the open group and both pipeline valids.
module base64_codec
	import b64_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	b64_in_if.sink    in_ch,
	b64_out_if.source out_ch
);

	logic        mode_q;
	logic [23:0] grp_bits_q;
	logic [1:0]  grp_cnt_q;
	logic        vld_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        free;
	logic        advance;
	logic [23:0] nxt_bits;
	logic [1:0]  nxt_cnt;
	res_grp_t    res;

	// a request with no results need not wait for the result buffer
	assign advance     = vld_s1 && (free || res.cnt == 3'd0);
	assign in_ch.ready = !vld_s1 || advance;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_in;
			last_s1 <= in_ch.last_in;
		end
	end

	// open group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_bits_q <= 24'h000000;
			grp_cnt_q  <= 2'd0;
		end else if (advance) begin
			grp_bits_q <= nxt_bits;
			grp_cnt_q  <= nxt_cnt;
		end
	end

	b64_step u_step (
		.mode     (mode_q),
		.data     (data_s1),
		.last     (last_s1),
		.grp_bits (grp_bits_q),
		.grp_cnt  (grp_cnt_q),
		.nxt_bits (nxt_bits),
		.nxt_cnt  (nxt_cnt),
		.res      (res)
	);

	b64_ser u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res    (res),
		.free   (free),
		.out_ch (out_ch)
	);

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 codec. A scoreboard class predicts every
// output character or byte from the accepted requests and checks the results
// in order. Directed requests cover padding, flushes, terminators, unknown
// characters and mode changes mid-group; random phases switch the mode,
// drive mostly well-formed base64 text with noise, and idle both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import b64_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 45;
	localparam logic [7:0] HIGH_CHAR_MIN = 8'h80;
	localparam string B64_CHARS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
	localparam int PAD_INDEX = 64;

	// receiver stall styles
	typedef enum int {RX_ALWAYS, RX_PATTERN, RX_COIN, RX_MOSTLY} rx_style_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} codec_result_t;

	// prediction of the codec and in-order checking of its results
	class b64_scoreboard;
		logic            mode;
		logic [23:0]     group_bits;
		logic [1:0]      group_count;
		codec_result_t   expected_out[$];
		int              errors;

		function new();
			mode = MODE_ENC;
			group_bits = '0;
			group_count = '0;
			errors = 0;
		endfunction

		function void set_mode(input logic m);
			mode = m;
		endfunction

		function int pending();
			return expected_out.size();
		endfunction

		function void push_result(input logic [7:0] b, input logic fin);
			codec_result_t r;
			r.out_byte = b;
			r.run_last = fin;
			expected_out.push_back(r);
		endfunction

		// alphabet position of a character, -1 when outside the alphabet
		function int sextet_of_char(input logic [7:0] c);
			for (int i = 0; i < 64; i++) begin
				if (B64_CHARS[i] == c) begin
					return i;
				end
			end
			return -1;
		endfunction

		function void encode_byte(input logic [7:0] d, input logic fin);
			int k;
			int sh;
			int v[4];
			logic [23:0] m;
			k = int'(group_count);
			if (k > 2) begin
				k = 2;
			end
			sh = 16 - 8 * k;
			group_bits = (group_bits & ~(24'hFF << sh)) | (24'(d) << sh);
			k++;
			if (k < 3 && !fin) begin
				group_count = 2'(k);
				return;
			end
			// bits of missing bytes count as zero
			m = group_bits & (24'hFFFFFF << (24 - 8 * k));
			v[0] = int'(m[23:18]);
			v[1] = int'(m[17:12]);
			v[2] = (k > 1) ? int'(m[11:6]) : PAD_INDEX;
			v[3] = (k > 2) ? int'(m[5:0]) : PAD_INDEX;
			for (int i = 0; i < 4; i++) begin
				push_result(B64_CHARS[v[i]], i == 3);
			end
			group_count = '0;
			group_bits = '0;
		endfunction

		// bytes of a decode group of k slots, unfilled slots keep old bits
		function void flush_decode(input int k);
			int n;
			logic [23:0] sh_bits;
			n = (k >= 4) ? 3 : ((k == 3) ? 2 : 1);
			for (int i = 0; i < n; i++) begin
				sh_bits = group_bits >> (16 - 8 * i);
				push_result(sh_bits[7:0], i + 1 == n);
			end
			group_count = '0;
		endfunction

		function void decode_char(input logic [7:0] c, input logic fin);
			int k;
			int s;
			int sh;
			k = int'(group_count);
			// terminator closes the open group, if any
			if (c == PAD_CHAR || c <= CTRL_MAX || c >= HIGH_CHAR_MIN) begin
				if (k != 0) begin
					flush_decode(k);
				end
				return;
			end
			s = sextet_of_char(c);
			if (s >= 0) begin
				sh = 18 - 6 * k;
				group_bits = (group_bits & ~(24'h3F << sh)) | (24'(s) << sh);
			end
			k++;
			if (k == 4 || fin) begin
				flush_decode(k);
			end else begin
				group_count = 2'(k);
			end
		endfunction

		function void note_request(input logic [7:0] d, input logic fin);
			if (mode == MODE_ENC) begin
				encode_byte(d, fin);
			end else begin
				decode_char(d, fin);
			end
		endfunction

		function void check_result(input logic [7:0] b, input logic fin);
			codec_result_t e;
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual out_byte=%h run_last=%b",
					$time, b, fin);
				errors++;
				return;
			end
			e = expected_out.pop_front();
			if (e.out_byte !== b) begin
				$display("%0t: out_byte mismatch, expected %h, actual %h", $time, e.out_byte, b);
				errors++;
			end
			if (e.run_last !== fin) begin
				$display("%0t: run_last mismatch, expected %b, actual %b", $time, e.run_last, fin);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	b64_in_if  in_ch();
	b64_out_if out_ch();

	b64_scoreboard sb = new();

	rx_style_t   rx_style;
	logic [15:0] rx_pat;
	logic [3:0]  rx_idx = '0;
	int          burst_left;
	int          burst_max;
	int          gap_max;
	int          cycle_cnt = 0;

	base64_codec i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
	end
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls
	always @(posedge clk) begin
		case (rx_style)
			RX_ALWAYS: begin
				out_ch.ready <= 1'b1;
			end
			RX_PATTERN: begin
				out_ch.ready <= rx_pat[rx_idx];
				rx_idx <= rx_idx + 4'd1;
			end
			RX_COIN: begin
				out_ch.ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				out_ch.ready <= ($urandom_range(0, 7) != 0);
			end
		endcase
	end

	// monitor: mode writes, accepted requests and results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				sb.set_mode(cfg_wdata);
			end
			if (in_ch.valid && in_ch.ready) begin
				sb.note_request(in_ch.data_in, in_ch.last_in);
			end
			if (out_ch.valid && out_ch.ready) begin
				sb.check_result(out_ch.out_byte, out_ch.run_last);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("** base64_codec: FAILED **");
			$finish;
		end
	end

	// one request, with bursts and gaps on the sender side
	task automatic send_item(input logic [7:0] d, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.data_in <= d;
		in_ch.last_in <= fin;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	// wait until every predicted result has come and the pipeline is empty
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random byte, or a character that ends a group or is outside the alphabet
	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: c = 8'($urandom_range(0, 255));
			1: c = 8'($urandom_range(0, CTRL_MAX));
			2: c = 8'($urandom_range(HIGH_CHAR_MIN, 255));
			3: c = PAD_CHAR;
			default: begin
				c = 8'($urandom_range(CTRL_MAX + 1, HIGH_CHAR_MIN - 1));
				while (sb.sextet_of_char(c) >= 0 || c == PAD_CHAR) begin
					c = 8'($urandom_range(CTRL_MAX + 1, HIGH_CHAR_MIN - 1));
				end
			end
		endcase
		return c;
	endfunction

	// one decode message: mostly padded base64 text, sometimes noise
	task automatic send_decode_message(inout int cnt);
		int groups;
		int pad;
		int n;
		if ($urandom_range(0, 4) != 0) begin
			groups = $urandom_range(1, 3);
			pad = $urandom_range(0, 2);
			n = 4 * groups - pad;
			for (int i = 0; i < n; i++) begin
				send_item(B64_CHARS[$urandom_range(0, 63)], pad == 0 && i == n - 1);
			end
			for (int j = 0; j < pad; j++) begin
				send_item(PAD_CHAR, j == pad - 1);
			end
			cnt += n + pad;
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				send_item(noise_char(), $urandom_range(0, 5) == 0);
			end
			cnt += n;
		end
	endtask

	task automatic run_directed();
		// {last_in, data_in}
		logic [8:0] enc_items[7] = '{
			9'h000, 9'h0FF, 9'h180,   // full group ended by last
			9'h101,                   // one byte, two pads
			9'h0AA, 9'h155,           // two bytes, one pad
			9'h04D                    // left open across the mode change
		};
		logic [8:0] dec_items[19] = '{
			9'h02B, 9'h02F, 9'h021,   // completes the group opened in encode mode
			9'h07E, 9'h041, 9'h07A, 9'h03D,   // unknown char, then pad ends three slots
			9'h020,                   // space with no open group
			9'h030, 9'h080,           // high byte ends one slot
			9'h0FF, 9'h000,           // terminators with no open group
			9'h039, 9'h061, 9'h13D,   // pad carrying last
			9'h151,                   // last on a single slot
			9'h07F, 9'h05A, 9'h07A    // three slots left open
		};
		burst_max = 4;
		gap_max = 2;
		rx_style = RX_PATTERN;
		write_mode(MODE_ENC);
		foreach (enc_items[i]) begin
			send_item(enc_items[i][7:0], enc_items[i][8]);
		end
		write_mode(MODE_DEC);
		foreach (dec_items[i]) begin
			send_item(dec_items[i][7:0], dec_items[i][8]);
		end
		// encode with three decode slots still counted
		write_mode(MODE_ENC);
		send_item(8'h10, 1'b1);
	endtask

	// stimulus
	initial begin
		logic ph_mode;
		int cnt;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_ENC;
		in_ch.valid <= 1'b0;
		in_ch.data_in <= '0;
		in_ch.last_in <= 1'b0;
		rx_style = RX_ALWAYS;
		rx_pat = 16'hA5C3;
		burst_left = 0;
		burst_max = 1;
		gap_max = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();

		for (int p = 0; p < 8; p++) begin
			if (p < 2) begin
				ph_mode = (p == 0) ? MODE_ENC : MODE_DEC;
			end else begin
				ph_mode = 1'($urandom_range(0, 1));
			end
			// first phase runs without idling on either side
			rx_style = (p == 0) ? RX_ALWAYS : rx_style_t'($urandom_range(0, 3));
			rx_pat = 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
			gap_max = (p == 0) ? 0 : $urandom_range(0, 6);
			burst_max = $urandom_range(1, 12);
			write_mode(ph_mode);
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				if (ph_mode == MODE_ENC) begin
					send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
					cnt++;
				end else begin
					send_decode_message(cnt);
				end
			end
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** base64_codec: PASSED **");
		end else begin
			$display("** base64_codec: FAILED **");
		end
		$finish;
	end

endmodule

[base64_codec.f]
rtl/b64_pkg.sv
rtl/b64_in_if.sv
rtl/b64_out_if.sv
rtl/b64_step.sv
rtl/b64_ser.sv
rtl/base64_codec.sv
tb/tb_top.sv
